### src/uisr_pkg.sv
// Package for the UTF-8 sanitizer: byte constants, the command record that
// goes from front to back, and the replacement byte lookup. No dependencies.
`default_nettype none

package uisr_pkg;

  // Result bytes one item may show before the rest is carried to the next item
  localparam int unsigned MaxResults = 10;

  // Command queue geometry
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // Replacement character U+FFFD
  localparam logic [7:0] ReplB0 = 8'hEF;
  localparam logic [7:0] ReplB1 = 8'hBF;
  localparam logic [7:0] ReplB2 = 8'hBD;

  // Byte classes
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContTag    = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Tag   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Tag   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Tag   = 8'hF0;

  // Overlong checks
  localparam logic [7:0] Over2LeadA = 8'hC0;
  localparam logic [7:0] Over2LeadB = 8'hC1;
  localparam logic [7:0] Over3Lead  = 8'hE0;
  localparam logic [7:0] Over3Min   = 8'hA0;
  localparam logic [7:0] Over4Lead  = 8'hF0;
  localparam logic [7:0] Over4Min   = 8'h90;

  // Sequence lengths
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  // One item's work: rep_count replacements, then raw_count raw bytes.
  // str_end marks the last of these bytes as the end of the string.
  typedef struct packed {
    logic [2:0]      rep_count;
    logic [2:0]      raw_count;
    logic [3:0][7:0] raw;
    logic            str_end;
  } cmd_t;

  // Byte q of a run of back-to-back replacements (EF BF BD EF BF BD ...)
  function automatic logic [7:0] repl_byte(input logic [3:0] q);
    logic [7:0] r;
    case (q) inside
      4'd0, 4'd3, 4'd6, 4'd9:  r = ReplB0;
      4'd1, 4'd4, 4'd7, 4'd10: r = ReplB1;
      default:                 r = ReplB2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/uisr_in_if.sv
// Input channel of the UTF-8 sanitizer: valid/ready plus one string byte.
// No dependencies.
`default_nettype none

interface uisr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_final;

  modport source(output valid, output in_byte, output in_final, input ready);
  modport sink(input valid, input in_byte, input in_final, output ready);
endinterface

`default_nettype wire

### src/uisr_out_if.sv
// Output channel of the UTF-8 sanitizer: valid/ready plus one result byte
// and its marks. No dependencies.
`default_nettype none

interface uisr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_replacement;
  logic       run_last;
  logic       string_end;

  modport source(output valid, output out_byte, output is_replacement,
                 output run_last, output string_end, input ready);
  modport sink(input valid, input out_byte, input is_replacement,
               input run_last, input string_end, output ready);
endinterface

`default_nettype wire

### src/uisr_front.sv
// Front end: accepts string bytes, tracks the pending multi-byte sequence
// and turns each item into a command. Uses uisr_pkg and uisr_in_if.
`default_nettype none

module uisr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  uisr_in_if.sink            in_ch,
  output logic               cmd_valid,
  output uisr_pkg::cmd_t     cmd,
  input  wire logic          cmd_ready
);

  // Pending sequence state
  logic [7:0]      held_lead;
  logic [1:0][7:0] held_cont;
  logic [1:0]      held_count;
  logic [2:0]      expected_length;

  logic [7:0]      held_lead_next;
  logic [1:0][7:0] held_cont_next;
  logic [1:0]      held_count_next;
  logic [2:0]      expected_length_next;

  logic [7:0] b;
  logic       fin;
  logic       accept;
  logic       is_cont;
  logic       fresh;
  logic       overlong;
  logic [7:0] first;
  logic [2:0] fresh_len;
  uisr_pkg::cmd_t c;

  assign b         = in_ch.in_byte;
  assign fin       = in_ch.in_final;
  assign accept    = in_ch.valid && cmd_ready;
  assign in_ch.ready = cmd_ready;
  assign cmd_valid = in_ch.valid;
  assign cmd       = c;

  // Classify the byte against the pending sequence
  always_comb begin
    c                    = '0;
    fresh                = 1'b1;
    overlong             = 1'b0;
    fresh_len            = uisr_pkg::LenNone;
    held_lead_next       = held_lead;
    held_cont_next       = held_cont;
    held_count_next      = held_count;
    expected_length_next = expected_length;
    is_cont = (b & uisr_pkg::ContMask) == uisr_pkg::ContTag;
    first   = (held_count == 2'd0) ? b : held_cont[0];

    if (expected_length != uisr_pkg::LenNone) begin
      if (is_cont) begin
        fresh = 1'b0;
        if ({1'b0, held_count} + 3'd2 >= expected_length) begin
          // sequence complete
          overlong =
            (expected_length == uisr_pkg::Len2 &&
             (held_lead == uisr_pkg::Over2LeadA || held_lead == uisr_pkg::Over2LeadB)) ||
            (expected_length == uisr_pkg::Len3 && held_lead == uisr_pkg::Over3Lead &&
             first < uisr_pkg::Over3Min) ||
            (expected_length == uisr_pkg::Len4 && held_lead == uisr_pkg::Over4Lead &&
             first < uisr_pkg::Over4Min);
          if (overlong) begin
            c.rep_count = 3'd1;
          end else begin
            c.raw_count = {1'b0, held_count} + 3'd2;
            c.raw[0]    = held_lead;
            c.raw[1]    = (held_count != 2'd0) ? held_cont[0] : b;
            c.raw[2]    = (held_count == 2'd2) ? held_cont[1] : b;
            c.raw[3]    = b;
          end
          expected_length_next = uisr_pkg::LenNone;
          held_count_next      = 2'd0;
        end else begin
          // hold another continuation
          held_cont_next[held_count[0]] = b;
          held_count_next               = held_count + 2'd1;
          if (fin) begin
            c.rep_count          = {1'b0, held_count} + 3'd2;
            expected_length_next = uisr_pkg::LenNone;
            held_count_next      = 2'd0;
          end
        end
      end else begin
        // broken sequence: lead and each held continuation get a replacement
        c.rep_count          = {1'b0, held_count} + 3'd1;
        expected_length_next = uisr_pkg::LenNone;
        held_count_next      = 2'd0;
      end
    end

    // Byte handled as if nothing were pending
    if (fresh) begin
      if (b < uisr_pkg::AsciiLimit) begin
        c.raw_count = 3'd1;
        c.raw[0]    = b;
      end else begin
        if ((b & uisr_pkg::Lead2Mask) == uisr_pkg::Lead2Tag) begin
          fresh_len = uisr_pkg::Len2;
        end else if ((b & uisr_pkg::Lead3Mask) == uisr_pkg::Lead3Tag) begin
          fresh_len = uisr_pkg::Len3;
        end else if ((b & uisr_pkg::Lead4Mask) == uisr_pkg::Lead4Tag) begin
          fresh_len = uisr_pkg::Len4;
        end
        if (fresh_len == uisr_pkg::LenNone || fin) begin
          c.rep_count = c.rep_count + 3'd1;
        end else begin
          held_lead_next       = b;
          held_count_next      = 2'd0;
          expected_length_next = fresh_len;
        end
      end
    end

    c.str_end = fin && (c.rep_count != 3'd0 || c.raw_count != 3'd0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead       <= '0;
      held_count      <= '0;
      expected_length <= uisr_pkg::LenNone;
    end else if (accept) begin
      held_lead       <= held_lead_next;
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
    end
  end

  // Held continuation bytes, written before read
  always_ff @(posedge clk) begin
    if (accept) begin
      held_cont <= held_cont_next;
    end
  end

endmodule

`default_nettype wire

### src/uisr_queue.sv
// Two-entry command queue between front and back of the UTF-8 sanitizer.
// Uses uisr_pkg.
`default_nettype none

module uisr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire uisr_pkg::cmd_t push_data,
  output logic                head_valid,
  output uisr_pkg::cmd_t      head,
  input  wire logic           pop
);

  uisr_pkg::cmd_t entries [uisr_pkg::QueueDepth];
  logic [uisr_pkg::QueuePtrW-1:0] wr_ptr;
  logic [uisr_pkg::QueuePtrW-1:0] rd_ptr;
  logic [uisr_pkg::QueueCntW-1:0] count;
  logic push;

  assign push_ready = count != uisr_pkg::QueueCntW'(uisr_pkg::QueueDepth);
  assign push       = push_valid && push_ready;
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + uisr_pkg::QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + uisr_pkg::QueuePtrW'(1);
      end
      if (push && !pop) begin
        count <= count + uisr_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
        count <= count - uisr_pkg::QueueCntW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### src/uisr_back.sv
// Back end: expands queued commands into result bytes, one per cycle while the
// output is not stalled, into an output register. Uses uisr_pkg and uisr_out_if.
`default_nettype none

module uisr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire uisr_pkg::cmd_t head,
  output logic                pop,
  uisr_out_if.source          out_ch
);

  // Position in the current item's byte list, carried bytes first
  logic [3:0] pos;
  // Two replacement bytes carried over from an item that overflowed
  logic       owed_valid;
  logic       owed_end;

  // Output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_rep;
  logic       out_last;
  logic       out_end;

  logic [4:0] owed_n;
  logic [4:0] rep3;
  logic [4:0] total;
  logic [4:0] p5;
  logic [4:0] q;
  logic [4:0] ri;
  logic [3:0] last_idx;
  logic       out_free;
  logic       empty_cmd;
  logic       is_last;
  logic       emit;
  logic [7:0] byte_c;
  logic       rep_c;
  logic       end_c;

  // Byte selection for the current position
  always_comb begin
    owed_n    = owed_valid ? 5'd2 : 5'd0;
    rep3      = {1'b0, head.rep_count, 1'b0} + {2'b00, head.rep_count};
    total     = owed_n + rep3 + {2'b00, head.raw_count};
    last_idx  = (total > 5'(uisr_pkg::MaxResults)) ? 4'(uisr_pkg::MaxResults - 1)
                                                   : total[3:0] - 4'd1;
    p5        = {1'b0, pos};
    q         = p5 - owed_n;
    ri        = q - rep3;
    out_free  = !out_valid || out_ch.ready;
    empty_cmd = total == 5'd0;
    is_last   = pos == last_idx;
    emit      = head_valid && !empty_cmd && out_free;
    pop       = head_valid && (empty_cmd || (out_free && is_last));

    if (p5 < owed_n) begin
      byte_c = pos[0] ? uisr_pkg::ReplB2 : uisr_pkg::ReplB1;
      rep_c  = 1'b1;
      end_c  = pos[0] && owed_end;
    end else begin
      if (q < rep3) begin
        byte_c = uisr_pkg::repl_byte(q[3:0]);
        rep_c  = 1'b1;
      end else begin
        byte_c = head.raw[ri[1:0]];
        rep_c  = 1'b0;
      end
      end_c = head.str_end && (p5 == total - 5'd1);
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      owed_valid <= 1'b0;
      owed_end   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        pos        <= '0;
        // only a 12-byte item overflows; its last two bytes are BF BD
        owed_valid <= total > 5'(uisr_pkg::MaxResults);
        owed_end   <= head.str_end;
      end else if (emit) begin
        pos <= pos + 4'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_c;
      out_rep  <= rep_c;
      out_last <= is_last;
      out_end  <= end_c;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.out_byte       = out_byte;
  assign out_ch.is_replacement = out_rep;
  assign out_ch.run_last       = out_last;
  assign out_ch.string_end     = out_end;

endmodule

`default_nettype wire

### src/utf8_invalid_sequence_replacer_unit.sv
// UTF-8 sanitizer: a string enters one byte per item and leaves with every bad
// sequence replaced by EF BF BD (U+FFFD). The front takes one input item per
// cycle while its two-entry command queue has room; the back sends one result
// byte per cycle while the output is not stalled, so an item holds the back for
// each of its result bytes (1 for ASCII, up to 10), and an item that gives no
// result byte (a lead byte being held) is popped by the back with no output.
// Sustained output is therefore set by the single output byte lane. Output is
// from a register; input flows while a result byte waits, until the queue fills.
// Uses uisr_pkg, uisr_in_if, uisr_out_if, uisr_front, uisr_queue, uisr_back.
`default_nettype none

module utf8_invalid_sequence_replacer_unit (
  input  wire logic clk,
  input  wire logic rst,
  uisr_in_if.sink   in_ch,
  uisr_out_if.source out_ch
);

  logic           cmd_valid;
  logic           cmd_ready;
  uisr_pkg::cmd_t cmd;
  logic           head_valid;
  uisr_pkg::cmd_t head;
  logic           pop;

  // Classify items
  uisr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // Decouple front and back
  uisr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (cmd),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Expand into result bytes
  uisr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### bench/uisr_checker.sv
`timescale 1ns / 1ps
// Checker for the UTF-8 sanitizer: watches both channels, predicts the cleaned
// byte stream from each accepted input item and compares every result byte.
// Uses uisr_pkg, uisr_in_if, uisr_out_if.

module uisr_checker (
  input  logic clk,
  input  logic rst,
  uisr_in_if   in_mon,
  uisr_out_if  out_mon,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       rep;
    logic       last;
    logic       str_end;
  } out_rec_t;

  // Pending sequence
  logic [7:0] lead_q;
  logic [7:0] cont_q [2];
  logic [1:0] held_n;
  logic [2:0] seq_len;

  out_rec_t carry_q [$];  // bytes spilled past the per-item limit
  out_rec_t step_q  [$];  // bytes caused by the current item
  out_rec_t due_q   [$];  // results still to arrive, oldest first
  int       err_n = 0;

  function automatic bit is_cont(input logic [7:0] b);
    return (b & uisr_pkg::ContMask) == uisr_pkg::ContTag;
  endfunction

  task automatic emit(input logic [7:0] b, input logic rep);
    step_q.push_back('{data: b, rep: rep, last: 1'b0, str_end: 1'b0});
  endtask

  task automatic emit_repl();
    emit(uisr_pkg::ReplB0, 1'b1);
    emit(uisr_pkg::ReplB1, 1'b1);
    emit(uisr_pkg::ReplB2, 1'b1);
  endtask

  // Lead and every held continuation each become one U+FFFD
  task automatic flush_held();
    emit_repl();
    for (int i = 0; i < held_n; i++) emit_repl();
    seq_len = uisr_pkg::LenNone;
    held_n  = 2'd0;
  endtask

  // Byte seen with nothing pending
  task automatic start_fresh(input logic [7:0] b, input logic fin);
    logic [2:0] len;
    len = uisr_pkg::LenNone;
    if (b < uisr_pkg::AsciiLimit) begin
      emit(b, 1'b0);
      return;
    end
    if ((b & uisr_pkg::Lead2Mask) == uisr_pkg::Lead2Tag) len = uisr_pkg::Len2;
    else if ((b & uisr_pkg::Lead3Mask) == uisr_pkg::Lead3Tag) len = uisr_pkg::Len3;
    else if ((b & uisr_pkg::Lead4Mask) == uisr_pkg::Lead4Tag) len = uisr_pkg::Len4;
    // stray continuation, F8..FF, or a lead on the last byte
    if (len == uisr_pkg::LenNone || fin) begin
      emit_repl();
      return;
    end
    lead_q  = b;
    held_n  = 2'd0;
    seq_len = len;
  endtask

  // Last continuation arrived: pass through unless overlong
  task automatic close_seq(input logic [7:0] b);
    logic [7:0] second;
    logic       overlong;
    second   = (held_n == 2'd0) ? b : cont_q[0];
    overlong = (seq_len == uisr_pkg::Len2 &&
                (lead_q == uisr_pkg::Over2LeadA || lead_q == uisr_pkg::Over2LeadB)) ||
               (seq_len == uisr_pkg::Len3 && lead_q == uisr_pkg::Over3Lead &&
                second < uisr_pkg::Over3Min) ||
               (seq_len == uisr_pkg::Len4 && lead_q == uisr_pkg::Over4Lead &&
                second < uisr_pkg::Over4Min);
    if (overlong) begin
      emit_repl();
    end else begin
      emit(lead_q, 1'b0);
      for (int i = 0; i < held_n; i++) emit(cont_q[i], 1'b0);
      emit(b, 1'b0);
    end
    seq_len = uisr_pkg::LenNone;
    held_n  = 2'd0;
  endtask

  task automatic predict_item(input logic [7:0] b, input logic fin);
    int       n0;
    int       n;
    bit       taken;
    out_rec_t r;
    step_q = carry_q;
    carry_q.delete();
    n0    = step_q.size();
    taken = 1'b0;
    if (seq_len != uisr_pkg::LenNone) begin
      if (is_cont(b)) begin
        if (int'(held_n) + 1 >= int'(seq_len) - 1) begin
          close_seq(b);
        end else begin
          cont_q[held_n[0]] = b;
          held_n++;
          if (fin) flush_held();
        end
        taken = 1'b1;
      end else begin
        flush_held();
      end
    end
    if (!taken) start_fresh(b, fin);
    // string end goes on this item's own last byte, not on carried ones
    if (fin && step_q.size() > n0) begin
      r = step_q[step_q.size() - 1];
      r.str_end = 1'b1;
      step_q[step_q.size() - 1] = r;
    end
    n = (step_q.size() > uisr_pkg::MaxResults) ? uisr_pkg::MaxResults : step_q.size();
    for (int i = 0; i < step_q.size(); i++) begin
      r = step_q[i];
      r.last = (i == n - 1);
      if (i < n) due_q.push_back(r);
      else if (carry_q.size() < 2) carry_q.push_back(step_q[i]);
    end
  endtask

  task automatic check_result();
    out_rec_t want;
    if (due_q.size() == 0) begin
      $error("unexpected result item: out_byte %h", out_mon.out_byte);
      err_n++;
      return;
    end
    want = due_q.pop_front();
    if (out_mon.out_byte !== want.data) begin
      $error("out_byte: expected %h, got %h", want.data, out_mon.out_byte);
      err_n++;
    end
    if (out_mon.is_replacement !== want.rep) begin
      $error("is_replacement: expected %b, got %b", want.rep, out_mon.is_replacement);
      err_n++;
    end
    if (out_mon.run_last !== want.last) begin
      $error("run_last: expected %b, got %b", want.last, out_mon.run_last);
      err_n++;
    end
    if (out_mon.string_end !== want.str_end) begin
      $error("string_end: expected %b, got %b", want.str_end, out_mon.string_end);
      err_n++;
    end
  endtask

  // Inputs are predicted before outputs are checked within one edge
  always @(posedge clk) begin
    if (rst) begin
      lead_q  = 8'h00;
      held_n  = 2'd0;
      seq_len = uisr_pkg::LenNone;
      carry_q.delete();
      due_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) predict_item(in_mon.in_byte, in_mon.in_final);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    errors      <= err_n;
    outstanding <= due_q.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the UTF-8 sanitizer bench: clock, reset, string stimulus and output
// stalls. Uses utf8_invalid_sequence_replacer_unit, both channel interfaces
// and uisr_checker.

module tb_top;

  localparam int unsigned RandomItems = 300;
  localparam int unsigned ResetCycles = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uisr_in_if  in_ch ();
  uisr_out_if out_ch ();

  int err_count;
  int pending_cnt;

  int unsigned items_sent = 0;
  logic [7:0]  str_q [$];

  // Directed string: {final, byte}
  logic [8:0] directed_q [$] = '{
    9'h000, 9'h07F,                   // ASCII extremes
    9'h0C3, 9'h0A9,                   // good 2-byte
    9'h0C0, 9'h080,                   // overlong 2-byte lead
    9'h0E0, 9'h09F, 9'h080,           // overlong 3-byte
    9'h0F0, 9'h09F, 9'h098, 9'h080,   // good 4-byte
    9'h080,                           // stray continuation
    9'h0FF,                           // byte that is never valid
    9'h0E2, 9'h041,                   // broken by ASCII
    9'h0F4, 9'h080, 9'h080, 9'h0FE,   // broken 4-byte, spills past the limit
    9'h0F4, 9'h08F, 9'h0BF, 9'h1C2,   // same, broken by a lead on the last byte
    9'h141                            // next string takes the carried bytes
  };

  bit          sink_calm  = 1'b0;
  int unsigned sink_hold  = 0;
  int unsigned calm_timer = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utf8_invalid_sequence_replacer_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  uisr_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .errors      (err_count),
    .outstanding (pending_cnt)
  );

  // Mostly short gaps, a few long ones; none while calm
  function automatic int unsigned gap_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic send_item(input logic [7:0] b, input logic fin, input bit calm);
    int unsigned g;
    g = gap_len(calm);
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.in_final <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Append one piece of text: mostly well formed, some overlong, cut or noise
  task automatic add_token();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      str_q.push_back(8'($urandom_range(0, 127)));
    end else if (r < 50) begin
      str_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
      str_q.push_back(cont_byte());
    end else if (r < 62) begin
      if ($urandom_range(0, 3) == 0) begin
        str_q.push_back(8'hE0);
        str_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
      end else begin
        str_q.push_back(8'($urandom_range(8'hE1, 8'hEF)));
        str_q.push_back(cont_byte());
      end
      str_q.push_back(cont_byte());
    end else if (r < 72) begin
      if ($urandom_range(0, 3) == 0) begin
        str_q.push_back(8'hF0);
        str_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
      end else begin
        str_q.push_back(8'($urandom_range(8'hF1, 8'hF7)));
        str_q.push_back(cont_byte());
      end
      str_q.push_back(cont_byte());
      str_q.push_back(cont_byte());
    end else if (r < 80) begin
      k = $urandom_range(0, 2);
      if (k == 0) begin
        str_q.push_back(8'($urandom_range(8'hC0, 8'hC1)));
      end else if (k == 1) begin
        str_q.push_back(8'hE0);
        str_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
      end else begin
        str_q.push_back(8'hF0);
        str_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
        str_q.push_back(cont_byte());
      end
      str_q.push_back(cont_byte());
    end else if (r < 88) begin
      // lead with too few continuations
      k = $urandom_range(2, 4);
      if (k == 2) str_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      else if (k == 3) str_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
      else str_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      repeat ($urandom_range(0, k - 2)) str_q.push_back(cont_byte());
    end else begin
      k = $urandom_range(0, 3);
      if (k < 2) str_q.push_back(8'($urandom_range(0, 255)));
      else if (k == 2) str_q.push_back(cont_byte());
      else str_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end
  endtask

  // Output stalls, with calm stretches now and then
  always @(posedge clk) begin : sink_ctl
    int unsigned g;
    if (calm_timer == 0) begin
      sink_calm  <= ($urandom_range(0, 4) == 0);
      calm_timer <= $urandom_range(100, 400);
    end else begin
      calm_timer <= calm_timer - 1;
    end
    if (sink_hold != 0) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else begin
      g = gap_len(sink_calm);
      out_ch.ready <= (g == 0);
      sink_hold    <= (g == 0) ? 0 : g - 1;
    end
  end

  initial begin : stim
    bit          calm;
    int unsigned n;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.in_final <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) send_item(directed_q[i][7:0], directed_q[i][8], 1'b0);

    // Random strings, final mark on the last byte of each
    while (items_sent < directed_q.size() + RandomItems) begin
      str_q.delete();
      n = $urandom_range(1, 6);
      repeat (n) add_token();
      calm = ($urandom_range(0, 5) == 0);
      foreach (str_q[i]) send_item(str_q[i], i == str_q.size() - 1, calm);
    end
    // one-byte string so that bytes carried from the last item come out
    send_item(8'h0A, 1'b1, 1'b0);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (err_count == 0 && pending_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
